/* hdl/qdec_pkg.sv */
// ----------------------------------------------------------------------------
// qdec_pkg: shared types and constants of the quadrature decoder
// Widths, sequence codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package qdec_pkg;

  // Timestamp arithmetic width (default of the top-level parameter)
  localparam int TIMESTAMP_BITS_DEF = 32;
  localparam int NOW_US_W           = 32;
  localparam int MS_SHIFT           = 10;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int STEP_W      = 17;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  // Phase transition check: bit i is set when history nibble i is a legal move
  localparam logic [15:0] VALID_TABLE = 16'b0110_1001_1001_0110;
  localparam logic [5:0]  SEQ_CW      = 6'b01_11_10;
  localparam logic [5:0]  SEQ_CCW     = 6'b10_11_01;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_DISCARD     = 2'd1,
    REG_FIX_DIR     = 2'd2
  } cfg_index_t;

  localparam logic [CFG_DATA_W-1:0] SENSITIVITY_RST = 8'd0;
  localparam logic [CFG_DATA_W-1:0] DISCARD_RST     = 8'd5;
  localparam logic [CFG_DATA_W-1:0] FIX_DIR_RST     = 8'd50;

  // Direction, two's complement -1, 0, +1
  typedef enum logic [1:0] {
    DIR_NONE = 2'b00,
    DIR_CW   = 2'b01,
    DIR_CCW  = 2'b11
  } dir_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] sensitivity;
    logic [CFG_DATA_W-1:0] discard_limit_ms;
    logic [CFG_DATA_W-1:0] fix_direction_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic [NOW_US_W-1:0] now_us;
    logic                phase_b;
    logic                phase_a;
  } in_item_t;

endpackage

/* hdl/qdec_cfg.sv */
// ----------------------------------------------------------------------------
// qdec_cfg: configuration register file
// Holds sensitivity, discard limit and fix-direction limit.
// ----------------------------------------------------------------------------
module qdec_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qdec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qdec_pkg::CFG_DATA_W-1:0]  cfg_data,
  output qdec_pkg::cfg_regs_t              regs
);
  import qdec_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sensitivity      <= SENSITIVITY_RST;
      regs.discard_limit_ms <= DISCARD_RST;
      regs.fix_direction_ms <= FIX_DIR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SENSITIVITY: regs.sensitivity      <= cfg_data;
        REG_DISCARD:     regs.discard_limit_ms <= cfg_data;
        REG_FIX_DIR:     regs.fix_direction_ms <= cfg_data;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

/* hdl/qdec_in_reg.sv */
// ----------------------------------------------------------------------------
// qdec_in_reg: input register
// Captures one sample word and holds it until the step logic takes it.
// ----------------------------------------------------------------------------
module qdec_in_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [qdec_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                            take,
  output logic                            item_valid,
  output qdec_pkg::in_item_t              item
);
  import qdec_pkg::*;

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.phase_a <= s_tdata[0];
      item.phase_b <= s_tdata[1];
      item.now_us  <= s_tdata[NOW_US_W+1:2];
    end
  end

endmodule

/* hdl/qdec_step.sv */
// ----------------------------------------------------------------------------
// qdec_step: phase tracking, step timing and result register
// Validates the phase transition, detects full steps, applies the timing
// rules and registers the signed step count.
// ----------------------------------------------------------------------------
module qdec_step #(
  parameter int TIMESTAMP_BITS = qdec_pkg::TIMESTAMP_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  input  qdec_pkg::in_item_t                 item,
  input  qdec_pkg::cfg_regs_t                regs,
  output logic                               take,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [qdec_pkg::STEP_W-1:0] step_count
);
  import qdec_pkg::*;

  localparam int GAP_W = TIMESTAMP_BITS - MS_SHIFT;
  localparam int CMP_W = (GAP_W > CFG_DATA_W) ? GAP_W : CFG_DATA_W;

  logic [5:0]                phase_history;
  logic [TIMESTAMP_BITS-1:0] last_step_time;
  dir_t                      last_direction;

  logic [5:0]                hist;
  logic                      legal;
  logic                      is_step;
  logic                      emit;
  logic [TIMESTAMP_BITS-1:0] now_ts;
  logic [TIMESTAMP_BITS-1:0] elapsed;
  logic [CMP_W-1:0]          gap;
  logic                      discard;
  logic                      accel;
  logic                      fix_dir;
  logic [CFG_DATA_W-1:0]     diff;
  logic [2*CFG_DATA_W-1:0]   mag;
  logic [STEP_W-1:0]         mag_ext;
  dir_t                      step_dir;
  dir_t                      dir_sel;
  logic [STEP_W-1:0]         step_count_next;

  assign take = item_valid && (!out_valid || out_ready);

  always_comb begin
    hist    = {phase_history[3:0], item.phase_b, item.phase_a};
    legal   = VALID_TABLE[hist[3:0]];
    is_step = legal && ((hist == SEQ_CW) || (hist == SEQ_CCW));
    step_dir = (hist == SEQ_CW) ? DIR_CW : DIR_CCW;

    now_ts  = TIMESTAMP_BITS'(item.now_us);
    elapsed = now_ts - last_step_time;
    gap     = CMP_W'(elapsed[TIMESTAMP_BITS-1:MS_SHIFT]);

    discard = gap < CMP_W'(regs.discard_limit_ms);
    accel   = gap < CMP_W'(regs.sensitivity);
    fix_dir = gap < CMP_W'(regs.fix_direction_ms);

    // under acceleration the gap is below sensitivity, so it fits 8 bits
    diff    = regs.sensitivity - gap[CFG_DATA_W-1:0];
    mag     = accel ? (diff * diff) : (2*CFG_DATA_W)'(1);
    mag_ext = STEP_W'(mag);

    dir_sel = fix_dir ? last_direction : step_dir;
    emit    = is_step && !discard;

    unique case (dir_sel)
      DIR_CW:   step_count_next = mag_ext;
      DIR_CCW:  step_count_next = -mag_ext;
      default:  step_count_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_history  <= '0;
      last_step_time <= '0;
      last_direction <= DIR_NONE;
      out_valid      <= 1'b0;
    end else if (take) begin
      if (legal) begin
        phase_history <= hist;
      end
      if (is_step) begin
        last_step_time <= now_ts;
      end
      if (emit) begin
        last_direction <= dir_sel;
      end
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      step_count <= step_count_next;
    end
  end

endmodule

/* hdl/quadrature_decoder_with_acceleration.sv */
// ----------------------------------------------------------------------------
// quadrature_decoder_with_acceleration: rotary encoder step decoder
// Turns timestamped contact samples into signed, speed-scaled step counts.
// ----------------------------------------------------------------------------
// Each input word is one sample of the two encoder contacts with its
// microsecond timestamp. A sample is kept only when exactly one contact
// changed; a kept 01-11-10 sequence is one clockwise step, 10-11-01 one
// counterclockwise step. The gap to the previous step, in units of 1024 us,
// drops the step when it is under discard_limit_ms, scales it by
// (sensitivity - gap)^2 when under sensitivity, and reuses the previous
// direction when under fix_direction_ms. A step that survives gives one
// output word with the signed count; every other sample gives none.
// Rate: one word per clock, sustained while the output is not stalled. An
// accepted word is loaded into the input register; the step logic then runs
// it into the result register, where output valid rises.
// The phase, timestamp and direction state updates in the same cycle that an
// item is evaluated, so consecutive words need no bubbles. A stalled output
// holds the input register; further words wait in s_tready.
// Configuration writes take effect the cycle after cfg_valid; cfg_ready is
// always high. Write registers only while the block is idle.
// ----------------------------------------------------------------------------
module quadrature_decoder_with_acceleration #(
  parameter int TIMESTAMP_BITS = qdec_pkg::TIMESTAMP_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  // sample stream
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [qdec_pkg::IN_TDATA_W-1:0]  s_tdata,   // [0] phase_a, [1] phase_b,
                                                      // [33:2] now_us, rest zero
  // step stream
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [qdec_pkg::OUT_TDATA_W-1:0] m_tdata,   // [16:0] step_count, rest zero
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qdec_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [qdec_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import qdec_pkg::*;

  cfg_regs_t          regs;
  in_item_t           item;
  logic               item_valid;
  logic               take;
  logic signed [STEP_W-1:0] step_count;

  // register file
  qdec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // hold one sample word in front of the step logic
  qdec_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  // evaluate the sample, advance the state and register the result
  qdec_step #(
    .TIMESTAMP_BITS (TIMESTAMP_BITS)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .regs       (regs),
    .take       (take),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .step_count (step_count)
  );

  // pad the count with zeros up to a whole number of bytes
  assign m_tdata = {{(OUT_TDATA_W-STEP_W){1'b0}}, step_count};

endmodule

/* hdl/qdec_checker.sv */
// ----------------------------------------------------------------------------
// qdec_checker: port-level checks of the quadrature decoder
// Watches the streams over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module qdec_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [qdec_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import qdec_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  // reset leaves no output word pending
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  // a rising output valid is preceded by an accepted sample
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("output word without an accepted sample");

  // count stays within the squared-sensitivity range, padding is zero
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_TDATA_W-1:STEP_W] == '0) &&
                 ($signed(m_tdata[STEP_W-1:0]) <= 17'sd65025) &&
                 ($signed(m_tdata[STEP_W-1:0]) >= -17'sd65025))
    else $error("step count out of range");

endmodule

bind quadrature_decoder_with_acceleration qdec_checker u_qdec_checker (.*);
